FILE: rtl/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg
// Types and fixed constants shared by the multi-joint slew limiter files.
// ----------------------------------------------------------------------------
package msl_pkg;

   // item kinds
   localparam logic [2:0] KIND_TICK       = 3'd0;
   localparam logic [2:0] KIND_STOP       = 3'd1;
   localparam logic [2:0] KIND_MOVE       = 3'd2;
   localparam logic [2:0] KIND_ACTIVATE   = 3'd3;
   localparam logic [2:0] KIND_DEACTIVATE = 3'd4;
   localparam logic [2:0] KIND_CONFIGURE  = 3'd5;

   // motion status codes
   localparam logic [1:0] MOTION_STOPPED = 2'd0;
   localparam logic [1:0] MOTION_MOVING  = 2'd1;
   localparam logic [1:0] MOTION_HOLDING = 2'd2;
   localparam logic [1:0] MOTION_FAULT   = 2'd3;

   // register indexes
   localparam logic [1:0] REG_JOINT_COUNT     = 2'd0;
   localparam logic [1:0] REG_FULL_STEP_LIMIT = 2'd1;
   localparam logic [1:0] REG_TICK_RATE       = 2'd2;
   localparam logic [1:0] REG_DEADBAND        = 2'd3;

   // register reset values
   localparam logic [2:0]  JOINT_COUNT_RESET     = 3'd6;
   localparam logic [19:0] FULL_STEP_LIMIT_RESET = 20'd655;
   localparam logic [9:0]  TICK_RATE_RESET       = 10'd50;
   localparam logic [15:0] DEADBAND_RESET        = 16'd7;

   // velocity scale, units of 1/1024
   localparam logic [10:0] SCALE_MIN   = 11'd51;
   localparam logic [10:0] SCALE_MAX   = 11'd1024;
   localparam logic [10:0] SCALE_RESET = 11'd512;

   // step limit is below 2**20, so a step fits in 21 signed bits
   localparam int STEP_BITS = 21;

   typedef struct packed {
      logic [2:0]         kind;
      logic [2:0]         joint_index;
      logic signed [31:0] target_position;
      logic [10:0]        speed_scale;
      logic [3:0]         target_count;
      logic               last_target;
   } req_type;

   typedef struct packed {
      logic [2:0]         joint_number;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic [1:0]         status;
      logic               last_joint;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  joint_count;
      logic [19:0] full_step_limit;
      logic [9:0]  tick_rate;
      logic [15:0] deadband;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic apply_configure;
      logic apply_activate;
      logic apply_deactivate;
      logic apply_stop;
      logic apply_move;
      logic load_limit;
      logic calc_error;
      logic calc_step;
      logic calc_velocity;
      logic next_joint;
      logic finish_tick;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic active;
      logic last_joint;
   } stat_type;

endpackage

FILE: rtl/multi_joint_slew_limiter_unit.sv
// ----------------------------------------------------------------------------
// multi_joint_slew_limiter_unit
// Moves up to MAX_JOINTS joint positions toward their targets, slew limited.
// ----------------------------------------------------------------------------
// Commands enter on the req_ channel (valid/ready), one transfer per command.
// Stop, move element, activate, deactivate and configure complete in the
// cycle of the transfer; req_ready stays high and the next command may follow
// in the next cycle.
// A tick on an active block emits one rsp_ transfer per joint in use, joint 0
// first, last_joint set on the final one. The sequencer loads the step limit,
// then takes each joint through three steps (error, clamp and sum, velocity
// multiply), updates the status, and then presents one result per joint.
// While results wait, req_ready is low; a stalled receiver holds the result
// and its payload steady until taken.
// Reset returns the sequencer to idle, zeroes positions and targets, sets
// status stopped, scale 512, inactive, and the registers to their defaults.
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12; pready is
// always high.
// ----------------------------------------------------------------------------
module multi_joint_slew_limiter_unit #(
   parameter int MAX_JOINTS    = 6,
   parameter int POSITION_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  msl_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output msl_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import msl_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   cmd_type  cmd;
   stat_type stat;
   logic     wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_JOINT_COUNT:     cfg_in.joint_count     = pwdata[2:0];
            REG_FULL_STEP_LIMIT: cfg_in.full_step_limit = pwdata[19:0];
            REG_TICK_RATE:       cfg_in.tick_rate       = pwdata[9:0];
            REG_DEADBAND:        cfg_in.deadband        = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.joint_count     <= JOINT_COUNT_RESET;
         cfg_ff.full_step_limit <= FULL_STEP_LIMIT_RESET;
         cfg_ff.tick_rate       <= TICK_RATE_RESET;
         cfg_ff.deadband        <= DEADBAND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_JOINT_COUNT:     prdata = 32'(cfg_ff.joint_count);
         REG_FULL_STEP_LIMIT: prdata = 32'(cfg_ff.full_step_limit);
         REG_TICK_RATE:       prdata = 32'(cfg_ff.tick_rate);
         REG_DEADBAND:        prdata = 32'(cfg_ff.deadband);
         default:             prdata = '0;
      endcase
   end

   msl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_data.kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   msl_dp #(
      .MAX_JOINTS    (MAX_JOINTS),
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/msl_ctrl.sv
// ----------------------------------------------------------------------------
// msl_ctrl
// Sequencer: decodes accepted items and walks the joints on a tick.
// ----------------------------------------------------------------------------
module msl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_kind,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  msl_pkg::stat_type  stat,
   output msl_pkg::cmd_type   cmd
);
   import msl_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LIMIT = 3'd1;
   localparam logic [2:0] ST_ERROR = 3'd2;
   localparam logic [2:0] ST_STEP  = 3'd3;
   localparam logic [2:0] ST_VEL   = 3'd4;
   localparam logic [2:0] ST_STAT  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_TICK: begin
                     if (stat.active) state_in = ST_LIMIT;
                  end
                  KIND_STOP:       cmd.apply_stop       = stat.active;
                  KIND_MOVE:       cmd.apply_move       = stat.active;
                  KIND_ACTIVATE:   cmd.apply_activate   = 1'b1;
                  KIND_DEACTIVATE: cmd.apply_deactivate = 1'b1;
                  KIND_CONFIGURE:  cmd.apply_configure  = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_LIMIT: begin
            cmd.load_limit = 1'b1;
            state_in       = ST_ERROR;
         end
         ST_ERROR: begin
            cmd.calc_error = 1'b1;
            state_in       = ST_STEP;
         end
         ST_STEP: begin
            cmd.calc_step = 1'b1;
            state_in      = ST_VEL;
         end
         ST_VEL: begin
            cmd.calc_velocity = 1'b1;
            if (stat.last_joint) begin
               state_in = ST_STAT;
            end else begin
               cmd.next_joint = 1'b1;
               state_in       = ST_ERROR;
            end
         end
         ST_STAT: begin
            cmd.finish_tick = 1'b1;
            state_in        = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (stat.last_joint) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_joint = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/msl_dp.sv
// ----------------------------------------------------------------------------
// msl_dp
// Joint state, target staging and the per-joint step arithmetic.
// ----------------------------------------------------------------------------
module msl_dp #(
   parameter int MAX_JOINTS    = 6,
   parameter int POSITION_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  msl_pkg::cmd_type  cmd,
   input  msl_pkg::req_type  req_data,
   input  msl_pkg::cfg_type  cfg,
   output msl_pkg::stat_type stat,
   output msl_pkg::rsp_type  rsp_data
);
   import msl_pkg::*;

   localparam int IW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int NW = IW + 1;
   localparam int PB = POSITION_BITS;
   localparam int WB = (PB > 32) ? PB : 32;
   localparam int XW = WB + 2;

   localparam logic signed [XW-1:0] PMAX_X = {{(XW-PB+1){1'b0}}, {(PB-1){1'b1}}};
   localparam logic signed [XW-1:0] PMIN_X = ~PMAX_X;

   logic signed [PB-1:0]        pos_ff   [MAX_JOINTS];
   logic signed [PB-1:0]        pos_in   [MAX_JOINTS];
   logic signed [PB-1:0]        tgt_ff   [MAX_JOINTS];
   logic signed [PB-1:0]        tgt_in   [MAX_JOINTS];
   logic signed [PB-1:0]        stg_ff   [MAX_JOINTS];
   logic signed [PB-1:0]        stg_in   [MAX_JOINTS];
   logic signed [31:0]          vel_ff   [MAX_JOINTS];
   logic signed [31:0]          vel_in   [MAX_JOINTS];
   logic [10:0]                 scale_ff, scale_in;
   logic [1:0]                  mstat_ff, mstat_in;
   logic                        active_ff, active_in;
   logic [IW-1:0]               jc_ff, jc_in;
   logic [19:0]                 lim_ff, lim_in;
   logic signed [XW-1:0]        err_ff, err_in;
   logic signed [STEP_BITS-1:0] step_ff, step_in;
   logic                        moved_ff, moved_in;

   logic [NW-1:0]        n_used;
   logic                 jc_last;
   logic [IW-1:0]        sidx;
   logic                 sidx_ok;
   logic                 commit_ok;
   logic signed [XW-1:0] tgt_x;
   logic signed [PB-1:0] tgt_sat;
   logic [10:0]          scale_clamp;
   logic [30:0]          lim_prod;
   logic signed [XW-1:0] diff_x;
   logic signed [XW-1:0] db_x;
   logic signed [XW-1:0] lim_x;
   logic                 go;
   logic signed [XW-1:0] step_x;
   logic signed [XW-1:0] sum_x;
   logic signed [PB-1:0] sum_sat;
   logic signed [31:0]   vprod;
   logic signed [XW-1:0] pos_out_x;

   // joints in use, clamped to 1..MAX_JOINTS
   always_comb begin
      if (cfg.joint_count == 3'd0) begin
         n_used = NW'(1);
      end else if (int'(cfg.joint_count) > MAX_JOINTS) begin
         n_used = NW'(MAX_JOINTS);
      end else begin
         n_used = NW'(cfg.joint_count);
      end
   end

   assign jc_last   = (({1'b0, jc_ff} + NW'(1)) == n_used);
   assign sidx      = IW'(req_data.joint_index);
   assign sidx_ok   = (int'(req_data.joint_index) < MAX_JOINTS);
   assign commit_ok = (int'(req_data.target_count) == int'(n_used));

   // saturate the incoming target to the position range
   assign tgt_x = XW'($signed(req_data.target_position));
   always_comb begin
      if (tgt_x > PMAX_X) begin
         tgt_sat = PMAX_X[PB-1:0];
      end else if (tgt_x < PMIN_X) begin
         tgt_sat = PMIN_X[PB-1:0];
      end else begin
         tgt_sat = tgt_x[PB-1:0];
      end
   end

   always_comb begin
      if (req_data.speed_scale < SCALE_MIN) begin
         scale_clamp = SCALE_MIN;
      end else if (req_data.speed_scale > SCALE_MAX) begin
         scale_clamp = SCALE_MAX;
      end else begin
         scale_clamp = req_data.speed_scale;
      end
   end

   assign lim_prod = 31'(cfg.full_step_limit) * 31'(scale_ff);
   assign diff_x   = XW'(tgt_ff[jc_ff]) - XW'(pos_ff[jc_ff]);
   assign db_x     = {{(XW-16){1'b0}}, cfg.deadband};
   assign lim_x    = {{(XW-20){1'b0}}, lim_ff};

   // clamp the error to the limit; an arrived joint takes no step
   assign go = (err_ff > db_x) || (err_ff < -db_x);
   always_comb begin
      if (!go) begin
         step_x = '0;
      end else if (err_ff > lim_x) begin
         step_x = lim_x;
      end else if (err_ff < -lim_x) begin
         step_x = -lim_x;
      end else begin
         step_x = err_ff;
      end
   end

   assign sum_x = XW'(pos_ff[jc_ff]) + step_x;
   always_comb begin
      if (sum_x > PMAX_X) begin
         sum_sat = PMAX_X[PB-1:0];
      end else if (sum_x < PMIN_X) begin
         sum_sat = PMIN_X[PB-1:0];
      end else begin
         sum_sat = sum_x[PB-1:0];
      end
   end

   // |step| < 2**20 and rate < 2**10, so the product never leaves 32 bits
   assign vprod = 32'(step_ff) * 32'($signed({1'b0, cfg.tick_rate}));

   always_comb begin
      pos_in    = pos_ff;
      tgt_in    = tgt_ff;
      stg_in    = stg_ff;
      vel_in    = vel_ff;
      scale_in  = scale_ff;
      mstat_in  = mstat_ff;
      active_in = active_ff;
      jc_in     = jc_ff;
      lim_in    = lim_ff;
      err_in    = err_ff;
      step_in   = step_ff;
      moved_in  = moved_ff;

      if (cmd.apply_configure) begin
         for (int i = 0; i < MAX_JOINTS; i++) begin
            pos_in[i] = '0;
            tgt_in[i] = '0;
         end
         mstat_in = MOTION_STOPPED;
      end
      if (cmd.apply_activate) active_in = 1'b1;
      if (cmd.apply_deactivate) begin
         active_in = 1'b0;
         mstat_in  = MOTION_HOLDING;
      end
      if (cmd.apply_stop) begin
         tgt_in   = pos_ff;
         mstat_in = MOTION_HOLDING;
      end
      if (cmd.apply_move) begin
         if (sidx_ok) stg_in[sidx] = tgt_sat;
         if (req_data.last_target) begin
            if (commit_ok) begin
               for (int i = 0; i < MAX_JOINTS; i++) begin
                  if (i < int'(n_used)) tgt_in[i] = stg_in[i];
               end
               scale_in = scale_clamp;
               mstat_in = MOTION_MOVING;
            end else begin
               mstat_in = MOTION_FAULT;
            end
         end
      end
      if (cmd.load_limit) begin
         lim_in   = lim_prod[29:10];
         jc_in    = '0;
         moved_in = 1'b0;
      end
      if (cmd.calc_error) err_in = diff_x;
      if (cmd.calc_step) begin
         pos_in[jc_ff] = sum_sat;
         step_in       = step_x[STEP_BITS-1:0];
         moved_in      = moved_ff | go;
      end
      if (cmd.calc_velocity) vel_in[jc_ff] = vprod;
      if (cmd.next_joint) jc_in = jc_ff + IW'(1);
      if (cmd.finish_tick) begin
         if (mstat_ff == MOTION_MOVING && !moved_ff) mstat_in = MOTION_STOPPED;
         jc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_JOINTS; i++) begin
            pos_ff[i] <= '0;
            tgt_ff[i] <= '0;
         end
         scale_ff  <= SCALE_RESET;
         mstat_ff  <= MOTION_STOPPED;
         active_ff <= 1'b0;
         jc_ff     <= '0;
         moved_ff  <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         tgt_ff    <= tgt_in;
         scale_ff  <= scale_in;
         mstat_ff  <= mstat_in;
         active_ff <= active_in;
         jc_ff     <= jc_in;
         moved_ff  <= moved_in;
      end
   end

   // payload only: no reset
   always_ff @(posedge clock) begin
      stg_ff  <= stg_in;
      vel_ff  <= vel_in;
      lim_ff  <= lim_in;
      err_ff  <= err_in;
      step_ff <= step_in;
   end

   assign stat.active     = active_ff;
   assign stat.last_joint = jc_last;

   assign pos_out_x             = XW'(pos_ff[jc_ff]);
   assign rsp_data.joint_number = 3'(jc_ff);
   assign rsp_data.position     = pos_out_x[31:0];
   assign rsp_data.velocity     = vel_ff[jc_ff];
   assign rsp_data.status       = mstat_ff;
   assign rsp_data.last_joint   = jc_last;

endmodule

FILE: rtl/msl_checker.sv
// ----------------------------------------------------------------------------
// msl_checker
// Port-level checks on the result sequence of the slew limiter.
// ----------------------------------------------------------------------------
module msl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input msl_pkg::rsp_type  rsp_data
);
   import msl_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // no command transfer while results are pending
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("command accepted while results pending");

   // results of one tick come out back to back, joint by joint
   a_joint_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_joint |=>
         rsp_valid &&
         rsp_data.joint_number == 3'($past(rsp_data.joint_number) + 3'd1))
      else $error("joint sequence broken");

   // after the last joint the block returns to taking commands
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_joint |=> req_ready && !rsp_valid)
      else $error("block not idle after last result");

endmodule

bind multi_joint_slew_limiter_unit msl_checker u_msl_checker (.*);

FILE: tb/tb_multi_joint_slew_limiter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_joint_slew_limiter_unit
// Self-checking bench for the multi-joint slew limiter. A directed table
// covers inactive commands, target extremes, out-of-range indexes, count
// mismatch, stop, deactivate and configure; random phases then drive mostly
// well-formed move trains followed by ticks under several register settings
// and idling patterns. Every result transfer is checked against a local model
// of the joint positions, targets, scale and status.
// ----------------------------------------------------------------------------
module tb_multi_joint_slew_limiter_unit;
   import msl_pkg::*;

   localparam int JOINTS        = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT   = 5000;
   localparam int UNTYPED       = -1;
   localparam logic [2:0] KIND_SPARE_A = 3'd6;
   localparam logic [2:0] KIND_SPARE_B = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      req_type item;
      int      n_due;
      int      status_due;
   } vector_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   multi_joint_slew_limiter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #2 clock = ~clock;

   // model state
   cfg_type     cfg_q = '{JOINT_COUNT_RESET, FULL_STEP_LIMIT_RESET, TICK_RATE_RESET,
                          DEADBAND_RESET};
   longint      pos_q    [JOINTS];
   longint      goal_q   [JOINTS];
   longint      staged_q [JOINTS];
   logic [10:0] scale_q  = SCALE_RESET;
   logic [1:0]  status_q = MOTION_STOPPED;
   bit          active_q = 1'b0;

   rsp_type     joint_reports_due[$];
   int          mismatch_count = 0;
   int          applied_items = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   bit          hold_off_req = 1'b0;
   int          quiet_cycles = 0;

   vector_row_type directed_rows [26] = '{
      '{'{KIND_TICK,       3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_STOP,       3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_MOVE,       3'd0, 32'sd1000,       11'd700,  4'd6,  1'b1}, 0, UNTYPED},
      '{'{KIND_ACTIVATE,   3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_TICK,       3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 6, MOTION_STOPPED},
      '{'{KIND_MOVE,       3'd0, 32'sh7FFFFFFF,   11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_MOVE,       3'd1, 32'sh80000000,   11'd2047, 4'd15, 1'b0}, 0, UNTYPED},
      '{'{KIND_MOVE,       3'd2, 32'sd100,        11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_MOVE,       3'd3, -32'sd5,         11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_MOVE,       3'd4, 32'sd7,          11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_MOVE,       3'd6, 32'sd555,        11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_MOVE,       3'd5, 32'sd8,          11'd2047, 4'd6,  1'b1}, 0, UNTYPED},
      '{'{KIND_TICK,       3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 6, MOTION_MOVING},
      '{'{KIND_MOVE,       3'd7, 32'sd0,          11'd0,    4'd6,  1'b1}, 0, UNTYPED},
      '{'{KIND_TICK,       3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 6, MOTION_MOVING},
      '{'{KIND_MOVE,       3'd0, 32'sd1234,       11'd300,  4'd5,  1'b1}, 0, UNTYPED},
      '{'{KIND_TICK,       3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 6, MOTION_FAULT},
      '{'{KIND_STOP,       3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_TICK,       3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 6, MOTION_HOLDING},
      '{'{KIND_SPARE_A,    3'd7, -32'sd1,         11'h7FF,  4'hF,  1'b1}, 0, UNTYPED},
      '{'{KIND_SPARE_B,    3'd7, -32'sd1,         11'h7FF,  4'hF,  1'b1}, 0, UNTYPED},
      '{'{KIND_DEACTIVATE, 3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_TICK,       3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_CONFIGURE,  3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_ACTIVATE,   3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 0, UNTYPED},
      '{'{KIND_TICK,       3'd0, 32'sd0,          11'd0,    4'd0,  1'b0}, 6, MOTION_STOPPED}
   };

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      $display("%0t: %s", $time, msg);
   endtask

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic int joints_in_use();
      int n;
      n = int'(cfg_q.joint_count);
      if (n < 1) n = 1;
      if (n > JOINTS) n = JOINTS;
      return n;
   endfunction

   // Update the joint model for one accepted command and queue the joint
   // reports it causes. Returns 0 when the block ignores the command.
   function automatic bit apply_command(input req_type it);
      int          n;
      int          j;
      longint      lim;
      longint      err;
      longint      mag;
      longint      stp;
      longint      vel [JOINTS];
      bit          moved;
      rsp_type     r;
      logic [10:0] sc;
      n = joints_in_use();
      case (it.kind)
         KIND_TICK: begin
            if (!active_q) return 1'b0;
            lim = (longint'(cfg_q.full_step_limit) * longint'(scale_q)) >>> 10;
            moved = 1'b0;
            for (j = 0; j < n; j++) begin
               err = goal_q[j] - pos_q[j];
               mag = (err < 0) ? -err : err;
               vel[j] = 0;
               if (mag > longint'(cfg_q.deadband)) begin
                  stp = err;
                  if (stp > lim) stp = lim;
                  if (stp < -lim) stp = -lim;
                  moved = 1'b1;
                  pos_q[j] = sat32(pos_q[j] + stp);
                  vel[j] = sat32(stp * longint'(cfg_q.tick_rate));
               end
            end
            if (status_q == MOTION_MOVING && !moved) status_q = MOTION_STOPPED;
            for (j = 0; j < n; j++) begin
               r.joint_number = 3'(j);
               r.position     = pos_q[j][31:0];
               r.velocity     = vel[j][31:0];
               r.status       = status_q;
               r.last_joint   = (j == n - 1);
               joint_reports_due.push_back(r);
            end
         end
         KIND_STOP: begin
            if (!active_q) return 1'b0;
            for (j = 0; j < JOINTS; j++) goal_q[j] = pos_q[j];
            status_q = MOTION_HOLDING;
         end
         KIND_MOVE: begin
            if (!active_q) return 1'b0;
            if (it.joint_index < JOINTS) begin
               staged_q[it.joint_index] = sat32(longint'(it.target_position));
            end
            if (it.last_target) begin
               if (int'(it.target_count) == n) begin
                  for (j = 0; j < n; j++) goal_q[j] = staged_q[j];
                  sc = it.speed_scale;
                  if (sc < SCALE_MIN) sc = SCALE_MIN;
                  if (sc > SCALE_MAX) sc = SCALE_MAX;
                  scale_q  = sc;
                  status_q = MOTION_MOVING;
               end else begin
                  status_q = MOTION_FAULT;
               end
            end
         end
         KIND_ACTIVATE: active_q = 1'b1;
         KIND_DEACTIVATE: begin
            active_q = 1'b0;
            status_q = MOTION_HOLDING;
         end
         KIND_CONFIGURE: begin
            for (j = 0; j < JOINTS; j++) begin
               pos_q[j]  = 0;
               goal_q[j] = 0;
            end
            status_q = MOTION_STOPPED;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic logic [31:0] reg_image(input logic [1:0] idx);
      case (idx)
         REG_JOINT_COUNT:     return 32'(cfg_q.joint_count);
         REG_FULL_STEP_LIMIT: return 32'(cfg_q.full_step_limit);
         REG_TICK_RATE:       return 32'(cfg_q.tick_rate);
         default:             return 32'(cfg_q.deadband);
      endcase
   endfunction

   // Write then read back one register; called and returns at a falling edge.
   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_JOINT_COUNT:     cfg_q.joint_count     = value[2:0];
         REG_FULL_STEP_LIMIT: cfg_q.full_step_limit = value[19:0];
         REG_TICK_RATE:       cfg_q.tick_rate       = value[9:0];
         default:             cfg_q.deadband        = value[15:0];
      endcase
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== reg_image(idx)) begin
         log_mismatch($sformatf("register %0d reads %h, expected %h",
                                idx, prdata, reg_image(idx)));
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Offer one command and hold it until the transfer; predict on acceptance.
   task automatic offer(input req_type it, input int n_due = UNTYPED,
                        input int status_due = UNTYPED);
      int queued_earlier;
      int k;
      while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      queued_earlier = joint_reports_due.size();
      if (apply_command(it)) applied_items++;
      if (n_due != UNTYPED && joint_reports_due.size() - queued_earlier != n_due) begin
         log_mismatch($sformatf("command kind %0d should cause %0d reports",
                                it.kind, n_due));
      end
      if (status_due != UNTYPED) begin
         for (k = queued_earlier; k < joint_reports_due.size(); k++) begin
            joint_reports_due[k].status = status_due[1:0];
         end
      end
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (joint_reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_type bare(input logic [2:0] kind);
      return '{kind, 3'($urandom), $urandom, 11'($urandom), 4'($urandom), 1'($urandom)};
   endfunction

   function automatic req_type move_item(input int j, input logic [31:0] tgt,
                                         input logic [3:0] cnt, input bit last);
      return '{KIND_MOVE, 3'(j), tgt, 11'($urandom_range(0, 2047)), cnt, last};
   endfunction

   // Mostly targets near the present position so joints arrive now and then.
   function automatic logic [31:0] pick_target(input int j);
      longint t;
      int     span;
      case ($urandom_range(0, 4))
         0:       span = 8;
         1:       span = int'(cfg_q.deadband) + 20;
         2:       span = 3000;
         3:       span = 300000;
         default: return $urandom;
      endcase
      t = pos_q[j % JOINTS] + longint'($urandom_range(0, 2 * span)) - span;
      t = sat32(t);
      return t[31:0];
   endfunction

   task automatic run_random(input int goal);
      int stop_at;
      int n;
      int j;
      int k;
      int r;
      stop_at = applied_items + goal;
      while (applied_items < stop_at) begin
         if (!active_q && $urandom_range(0, 9) != 0) offer(bare(KIND_ACTIVATE));
         n = joints_in_use();
         r = $urandom_range(0, 99);
         if (r < 55) begin
            for (j = 0; j < n; j++) begin
               offer(move_item(j, pick_target(j), 4'(n), j == n - 1));
            end
            k = $urandom_range(1, 6);
            repeat (k) offer(bare(KIND_TICK));
         end else if (r < 67) begin
            k = $urandom_range(1, 3);
            repeat (k) offer(bare(KIND_TICK));
         end else if (r < 73) begin
            offer(bare(KIND_STOP));
            offer(bare(KIND_TICK));
         end else if (r < 80) begin
            // broken train: stray indexes and an arbitrary count on the last element
            k = $urandom_range(1, n);
            for (j = 0; j < k; j++) begin
               offer(move_item($urandom_range(0, 7), pick_target(j), 4'($urandom),
                               j == k - 1));
            end
            offer(bare(KIND_TICK));
         end else if (r < 85) begin
            offer(bare(KIND_DEACTIVATE));
            offer(bare(KIND_TICK));
            offer(bare(KIND_MOVE));
         end else if (r < 88) begin
            offer(bare(KIND_CONFIGURE));
         end else if (r < 91) begin
            offer(bare($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B));
         end else begin
            offer(bare(3'($urandom)));
         end
      end
   endtask

   task automatic run_phase(input logic [2:0] jc, input logic [19:0] fsl,
                            input logic [9:0] rate, input logic [15:0] db,
                            input idle_mode_type mode, input int goal,
                            input bit long_hold);
      settle();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      write_register(REG_JOINT_COUNT, 32'(jc));
      write_register(REG_FULL_STEP_LIMIT, 32'(fsl));
      write_register(REG_TICK_RATE, 32'(rate));
      write_register(REG_DEADBAND, 32'(db));
      case (mode)
         IDLE_SENDER:   sender_idle_pct = 69;
         IDLE_RECEIVER: receiver_stall_pct = 69;
         IDLE_BOTH: begin
            sender_idle_pct    = 11;
            receiver_stall_pct = 11;
         end
         default: ;
      endcase
      if (long_hold) hold_off_req = 1'b1;
      run_random(goal);
   endtask

   // receiver: random stalls, plus one long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready    <= 1'b0;
            hold_off_req = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= !(receiver_stall_pct > 0 &&
                           $urandom_range(0, 99) < receiver_stall_pct);
         end
      end
   end

   task automatic match_report(input rsp_type got);
      rsp_type due;
      if (joint_reports_due.size() == 0) begin
         log_mismatch($sformatf("unexpected report for joint %0d", got.joint_number));
      end else begin
         due = joint_reports_due.pop_front();
         if (got.joint_number !== due.joint_number)
            log_mismatch($sformatf("joint_number %0d, expected %0d",
                                   got.joint_number, due.joint_number));
         if (got.position !== due.position)
            log_mismatch($sformatf("joint %0d position %0d, expected %0d",
                                   due.joint_number, got.position, due.position));
         if (got.velocity !== due.velocity)
            log_mismatch($sformatf("joint %0d velocity %0d, expected %0d",
                                   due.joint_number, got.velocity, due.velocity));
         if (got.status !== due.status)
            log_mismatch($sformatf("joint %0d status %0d, expected %0d",
                                   due.joint_number, got.status, due.status));
         if (got.last_joint !== due.last_joint)
            log_mismatch($sformatf("joint %0d last_joint %0b, expected %0b",
                                   due.joint_number, got.last_joint, due.last_joint));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) match_report(rsp_data);
   end

   // watchdog: count cycles without any transfer
   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         offer(directed_rows[i].item, directed_rows[i].n_due, directed_rows[i].status_due);
      end
      run_phase(3'd6, 20'd655, 10'd50, 16'd7, IDLE_NONE, 80, 1'b0);
      run_phase(3'd1, 20'd0, 10'd1, 16'd0, IDLE_SENDER, 60, 1'b0);
      run_phase(3'd3, 20'hFFFFF, 10'd1000, 16'hFFFF, IDLE_RECEIVER, 60, 1'b1);
      run_phase(3'd0, 20'd4000, 10'h3FF, 16'd100, IDLE_BOTH, 60, 1'b0);
      run_phase(3'd7, 20'($urandom), 10'($urandom), 16'($urandom), IDLE_NONE, 60, 1'b1);
      run_phase(3'd6, 20'd20000, 10'd100, 16'd3, IDLE_SENDER, 80, 1'b0);
      run_phase(3'd2, 20'd12345, 10'd500, 16'd50, IDLE_RECEIVER, 80, 1'b0);
      settle();
      if (mismatch_count == 0 && joint_reports_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
